@@ rtl/sdcfi_pkg.sv @@
// Shared constants, register codes and inter-module structs for the
// stereo DC blocker with fade-in. No dependencies.
`timescale 1ns / 1ps

package sdcfi_pkg;

  // Fixed-point format of the filter value
  localparam int FRACTION_BITS = 12;

  localparam int SAMPLE_W    = 16;
  localparam int VALUE_W     = 32;
  localparam int POLE_W      = 16;
  localparam int FADE_W      = 24;
  localparam int FRAME_W     = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  // Full scale is 2^(15+FRACTION_BITS)
  localparam int OUT_SHIFT    = 15 + FRACTION_BITS;
  localparam int DIFF_W       = SAMPLE_W + 1 + FRACTION_BITS;
  localparam int FB_PROD_W    = POLE_W + 1 + VALUE_W;
  localparam int FB_W         = FB_PROD_W - 16;
  localparam int SUM_W        = ((DIFF_W > FB_W) ? DIFF_W : FB_W) + 1;
  localparam int SCALE_PROD_W = VALUE_W + SAMPLE_W;
  localparam int DIV_CNT_W    = $clog2(VALUE_W);

  // About 1e-5 of full scale
  localparam logic signed [VALUE_W-1:0] AUDIBLE_LIMIT =
    VALUE_W'(21474 >> (16 - FRACTION_BITS));
  localparam logic signed [SAMPLE_W-1:0] OUT_GAIN = 16'sd32767;
  localparam logic [POLE_W-1:0] POLE_RESET = 16'd65503;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DC_BLOCK_ENABLE = 2'd0,
    REG_DC_POLE         = 2'd1,
    REG_FADE_LENGTH     = 2'd2,
    REG_FRAME_LIMIT     = 2'd3
  } cfg_reg_t;

  // Second-phase command from the merge stage to both lanes
  typedef struct packed {
    logic              go;
    logic              apply;
    logic [FADE_W-1:0] count;
    logic [FADE_W-1:0] length;
  } fade_cmd_t;

  // Lane progress seen by the merge stage
  typedef struct packed {
    logic filt_ready;
    logic done;
  } lane_status_t;

endpackage

@@ rtl/sdcfi_lane.sv @@
// One channel lane: DC blocking filter, fade gain with a serial divider,
// output scaling and saturation. Depends on sdcfi_pkg.
`timescale 1ns / 1ps

module sdcfi_lane (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [sdcfi_pkg::SAMPLE_W-1:0] sample,
  input  logic                                  enable,
  input  logic [sdcfi_pkg::POLE_W-1:0]          pole,
  input  sdcfi_pkg::fade_cmd_t                  cmd,
  input  logic                                  ack,
  output sdcfi_pkg::lane_status_t               status,
  output logic signed [sdcfi_pkg::VALUE_W-1:0]  value,
  output logic signed [sdcfi_pkg::SAMPLE_W-1:0] result
);
  import sdcfi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FB_MUL, S_SUM, S_WAIT, S_DIV, S_FIX, S_SCALE_MUL, S_SAT, S_DONE
  } lane_state_t;

  lane_state_t                  state;
  logic signed [SAMPLE_W-1:0]   x;
  logic signed [SAMPLE_W-1:0]   prev_in;
  logic signed [VALUE_W-1:0]    prev_out;
  logic signed [VALUE_W-1:0]    v;
  logic signed [FB_PROD_W-1:0]  prod_fb;
  logic signed [SCALE_PROD_W-1:0] prod_scale;
  logic [FADE_W-1:0]            rem;
  logic [VALUE_W-1:0]           quo;
  logic [FADE_W-1:0]            divisor;
  logic [DIV_CNT_W-1:0]         div_cnt;
  logic                         neg;

  logic signed [SAMPLE_W:0]     d;
  logic signed [DIFF_W-1:0]     diff_shift;
  logic signed [FB_W-1:0]       fb;
  logic signed [SUM_W-1:0]      sum;
  logic signed [VALUE_W-1:0]    sum_sat;
  logic [VALUE_W-1:0]           v_abs;
  logic [FADE_W:0]              trial;
  logic [FADE_W:0]              trial_sub;
  logic                         ge;
  logic [FADE_W-1:0]            rem_next;
  logic [SCALE_PROD_W-1:0]      bias;
  logic signed [SCALE_PROD_W-1:0] scaled;
  logic signed [SAMPLE_W-1:0]   out_sat;

  // Filter sum: difference term plus floored feedback, saturated to 32 bits
  assign d          = $signed({x[SAMPLE_W-1], x}) - $signed({prev_in[SAMPLE_W-1], prev_in});
  assign diff_shift = $signed({d, {FRACTION_BITS{1'b0}}});
  assign fb         = $signed(prod_fb[FB_PROD_W-1:16]);
  assign sum        = SUM_W'(diff_shift) + SUM_W'(fb);

  always_comb begin
    if ((&sum[SUM_W-1:VALUE_W-1]) || !(|sum[SUM_W-1:VALUE_W-1])) begin
      sum_sat = sum[VALUE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sum_sat = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  // Magnitude for the fade product
  assign v_abs = v[VALUE_W-1] ? (~v + 1'b1) : v;

  // One restoring division step per cycle
  assign trial     = {rem, quo[VALUE_W-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign ge        = (trial >= {1'b0, divisor});
  assign rem_next  = ge ? trial_sub[FADE_W-1:0] : trial[FADE_W-1:0];

  // Scale to int16: truncate toward zero, then saturate
  assign bias   = prod_scale[SCALE_PROD_W-1] ?
                  {{(SCALE_PROD_W-OUT_SHIFT){1'b0}}, {OUT_SHIFT{1'b1}}} : '0;
  assign scaled = $signed(prod_scale + bias) >>> OUT_SHIFT;

  always_comb begin
    if ((&scaled[SCALE_PROD_W-1:SAMPLE_W-1]) || !(|scaled[SCALE_PROD_W-1:SAMPLE_W-1])) begin
      out_sat = scaled[SAMPLE_W-1:0];
    end else if (scaled[SCALE_PROD_W-1]) begin
      out_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      out_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // Sequence one sample through the lane
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      prev_in  <= '0;
      prev_out <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            x <= sample;
            if (enable) begin
              state <= S_FB_MUL;
            end else begin
              v     <= VALUE_W'(sample) <<< FRACTION_BITS;
              state <= S_WAIT;
            end
          end
        end
        S_FB_MUL: begin
          prod_fb <= $signed({1'b0, pole}) * prev_out;
          state   <= S_SUM;
        end
        S_SUM: begin
          v        <= sum_sat;
          prev_out <= sum_sat;
          prev_in  <= x;
          state    <= S_WAIT;
        end
        S_WAIT: begin
          if (cmd.go) begin
            if (cmd.apply) begin
              neg          <= v[VALUE_W-1];
              divisor      <= cmd.length;
              {rem, quo}   <= v_abs * cmd.count;
              div_cnt      <= '0;
              state        <= S_DIV;
            end else begin
              state <= S_SCALE_MUL;
            end
          end
        end
        S_DIV: begin
          rem     <= rem_next;
          quo     <= {quo[VALUE_W-2:0], ge};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(VALUE_W - 1)) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          v     <= neg ? $signed(~quo + 1'b1) : $signed(quo);
          state <= S_SCALE_MUL;
        end
        S_SCALE_MUL: begin
          prod_scale <= v * OUT_GAIN;
          state      <= S_SAT;
        end
        S_SAT: begin
          result <= out_sat;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (ack) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status.filt_ready = (state == S_WAIT);
  assign status.done       = (state == S_DONE);
  assign value             = v;

endmodule

@@ rtl/stereo_dc_block_fade_in.sv @@
// Stereo DC blocker with fade-in: configuration registers, fade and frame
// control merging both lanes, output register. Depends on sdcfi_pkg, sdcfi_lane.
`timescale 1ns / 1ps
// A new input request is taken only once the previous frame has been loaded
// into the output register. Each lane runs the filter (when it is on), the
// fade gain through its 32-step serial divider (while the fade gain applies),
// then scaling and saturation; a waiting output does not block acceptance
// of the next request.
// Reset (synchronous, active high) clears all filter, fade and frame state.

module stereo_dc_block_fade_in (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [31:0]                          s_axis_tdata,  // left_sample, right_sample
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [31:0]                          m_axis_tdata,  // left_out, right_out
  input  logic                                 cfg_we,
  input  logic [sdcfi_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sdcfi_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sdcfi_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_FILT, T_RUN} top_state_t;

  top_state_t              state;
  logic                    dc_block_enable;
  logic [POLE_W-1:0]       dc_pole;
  logic [FADE_W-1:0]       fade_length;
  logic [FRAME_W-1:0]      frame_limit;
  logic [FADE_W-1:0]       fade_count;
  logic                    audible_seen;
  logic [FRAME_W-1:0]      frames_emitted;
  logic                    out_valid;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;

  lane_status_t            lstat;
  lane_status_t            rstat;
  fade_cmd_t               cmd;
  logic signed [VALUE_W-1:0]  vl;
  logic signed [VALUE_W-1:0]  vr;
  logic signed [SAMPLE_W-1:0] res_l;
  logic signed [SAMPLE_W-1:0] res_r;
  logic                    accept;
  logic                    limit_hit;
  logic                    start;
  logic                    fade_active;
  logic                    loud;
  logic                    seen_next;
  logic                    load;

  assign s_axis_tready = (state == T_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign limit_hit     = (frames_emitted >= frame_limit);
  assign start         = accept && !limit_hit;

  // Merge: audible test on the left value decides the fade for both lanes
  assign fade_active = (fade_length != '0) && (fade_count < fade_length);
  assign loud        = (vl > AUDIBLE_LIMIT) || (vl < -AUDIBLE_LIMIT);
  assign seen_next   = audible_seen || (fade_active && loud);

  assign cmd.go     = (state == T_FILT) && lstat.filt_ready && rstat.filt_ready;
  assign cmd.apply  = fade_active && seen_next;
  assign cmd.count  = fade_count;
  assign cmd.length = fade_length;

  assign load = (state == T_RUN) && lstat.done && rstat.done &&
                (!out_valid || m_axis_tready);

  sdcfi_lane u_lane_left (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .sample ($signed(s_axis_tdata[15:0])),
    .enable (dc_block_enable),
    .pole   (dc_pole),
    .cmd    (cmd),
    .ack    (load),
    .status (lstat),
    .value  (vl),
    .result (res_l)
  );

  sdcfi_lane u_lane_right (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .sample ($signed(s_axis_tdata[31:16])),
    .enable (dc_block_enable),
    .pole   (dc_pole),
    .cmd    (cmd),
    .ack    (load),
    .status (rstat),
    .value  (vr),
    .result (res_r)
  );

  // Control state, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= T_IDLE;
      dc_block_enable <= 1'b0;
      dc_pole         <= POLE_RESET;
      fade_length     <= '0;
      frame_limit     <= '0;
      fade_count      <= '0;
      audible_seen    <= 1'b0;
      frames_emitted  <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_DC_BLOCK_ENABLE: dc_block_enable <= cfg_data[0];
          REG_DC_POLE:         dc_pole         <= cfg_data[POLE_W-1:0];
          REG_FADE_LENGTH:     fade_length     <= cfg_data[FADE_W-1:0];
          REG_FRAME_LIMIT:     frame_limit     <= cfg_data[FRAME_W-1:0];
          default: ;
        endcase
      end

      if (m_axis_tready && !load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        T_IDLE: begin
          // drop the request silently once the frame limit is reached
          if (start) begin
            state <= T_FILT;
          end
        end
        T_FILT: begin
          if (cmd.go) begin
            if (fade_active) begin
              audible_seen <= seen_next;
            end
            if (cmd.apply) begin
              fade_count <= fade_count + 1'b1;
            end
            state <= T_RUN;
          end
        end
        T_RUN: begin
          if (load) begin
            out_valid      <= 1'b1;
            out_left       <= res_l;
            out_right      <= res_r;
            frames_emitted <= frames_emitted + 1'b1;
            state          <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_right, out_left};

  // Lanes run in lockstep
  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    lstat == rstat)
    else $error("lanes out of step");

  // The left lane holds no work while a new request may be taken
  a_idle_lanes: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (!lstat.filt_ready && !lstat.done))
    else $error("lane busy while accepting");

  // Each delivered frame is counted once
  a_frame_count: assert property (@(posedge clk) disable iff (rst)
    load |=> (frames_emitted == $past(frames_emitted) + 1'b1) && out_valid)
    else $error("frame count did not advance");

  // A fade command only follows a filtered pair from both lanes
  a_cmd_order: assert property (@(posedge clk) disable iff (rst)
    cmd.go |=> (state == T_RUN) && !lstat.filt_ready)
    else $error("fade command out of order");

  // With the filter off both values are plain shifted samples
  a_bypass_value: assert property (@(posedge clk) disable iff (rst)
    (cmd.go && !dc_block_enable) |->
      (vl[FRACTION_BITS-1:0] == '0) && (vr[FRACTION_BITS-1:0] == '0))
    else $error("bypass value not aligned");

endmodule
